// ===== design/psvos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvos_pkg
// Shared types and constants for the per-symbol tick statistics block.
// ----------------------------------------------------------------------------
package psvos_pkg;

    // Table size default and the widest slot index the item format carries
    localparam int SYMBOLS_DEF = 256;
    localparam int SLOT_W_MAX  = 16;

    // Basis points per unit of relative change
    localparam logic [13:0] BP_SCALE = 14'd10000;

    // Clamp values
    localparam logic [31:0] VWAP_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] BP_MAX   = 32'h7FFF_FFFF;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        FN_TICK    = 2'd0,
        FN_QUERY   = 2'd1,
        FN_RST_ONE = 2'd2,
        FN_RST_ALL = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_APPLIED  = 3'd0,
        ST_BAD      = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_RESET    = 3'd4,
        ST_SAT      = 3'd5
    } status_t;

    // Classified item held in the queue between front and back
    typedef struct packed {
        func_t                 func;
        logic [7:0]            symbol;
        logic [SLOT_W_MAX-1:0] slot;
        logic [31:0]           price;
        logic [23:0]           volume;
    } item_t;

    // One slot of the statistics table
    typedef struct packed {
        logic        valid;
        logic        sat;
        logic [31:0] open;
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] last;
        logic [47:0] vol;
        logic [31:0] cnt;
        logic [63:0] pv;
    } stats_t;

    // Divider result toward the sequencer
    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quot;
    } div_res_t;

endpackage

// ===== design/per_symbol_vwap_ohlc_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_symbol_vwap_ohlc_stats
// Per-symbol session statistics (OHLC, volume, tick count, VWAP, change)
// for market ticks, with query and session reset.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   func, symbol_id, price, volume
//   out      out_valid/out_stall status, symbol_echo, stats fields
//
// A tick with a good price and a query that hits each make two passes
// through the shared radix-2 divider (VWAP, then basis points). Reset all
// sweeps the table. After reset a clearing pass over all SYMBOLS slots runs;
// no item is taken then. A two-item queue and the result register let either
// side stall alone.
// ----------------------------------------------------------------------------
module per_symbol_vwap_ohlc_stats #(
    parameter int SYMBOLS = psvos_pkg::SYMBOLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [7:0]         symbol_id,
    input  logic [31:0]        price,
    input  logic [23:0]        volume,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [7:0]         symbol_echo,
    output logic [31:0]        last_px,
    output logic [31:0]        open_price,
    output logic [31:0]        high_price,
    output logic [31:0]        low_price,
    output logic [47:0]        volume_total,
    output logic [31:0]        tick_total,
    output logic [31:0]        vwap,
    output logic signed [32:0] px_change,
    output logic signed [31:0] change_bp
);

    logic             q_valid;
    logic             q_pop;
    logic             clearing;
    psvos_pkg::item_t q_item;

    psvos_front #(
        .SYMBOLS (SYMBOLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .symbol_id (symbol_id),
        .price     (price),
        .volume    (volume),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    psvos_back #(
        .SYMBOLS (SYMBOLS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .symbol_echo  (symbol_echo),
        .last_px      (last_px),
        .open_price   (open_price),
        .high_price   (high_price),
        .low_price    (low_price),
        .volume_total (volume_total),
        .tick_total   (tick_total),
        .vwap         (vwap),
        .px_change    (px_change),
        .change_bp    (change_bp)
    );

endmodule

// ===== design/psvos_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvos_front
// Input side: takes items, maps the symbol onto a table slot and queues
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module psvos_front #(
    parameter int SYMBOLS = psvos_pkg::SYMBOLS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       func,
    input  logic [7:0]       symbol_id,
    input  logic [31:0]      price,
    input  logic [23:0]      volume,
    input  logic             clearing,
    output logic             q_valid,
    output psvos_pkg::item_t q_item,
    input  logic             q_pop
);

    psvos_pkg::item_t q_mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             push;
    logic [31:0]      rem;
    logic [31:0]      sub;
    psvos_pkg::item_t new_item;

    // Slot = symbol mod SYMBOLS, restoring reduction one bit per step
    always_comb
    begin
        rem = {24'd0, symbol_id};
        sub = '0;
        for (int k = 7; k >= 0; k--)
        begin
            sub = 32'(SYMBOLS) << k;
            if (rem >= sub)
            begin
                rem = rem - sub;
            end
        end
    end

    always_comb
    begin
        new_item.func   = psvos_pkg::func_t'(func);
        new_item.symbol = symbol_id;
        new_item.slot   = rem[psvos_pkg::SLOT_W_MAX-1:0];
        new_item.price  = price;
        new_item.volume = volume;
    end

    // Handshake
    assign in_stall = (cnt_reg == 2'd2) || clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

`ifndef SYNTHESIS
    // Back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");
`endif

endmodule

// ===== design/psvos_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvos_div
// Radix-2 restoring divider: 64-bit dividend by 48-bit divisor, 32-bit
// quotient in 32 steps, flags a quotient that does not fit 32 bits.
// ----------------------------------------------------------------------------
module psvos_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [63:0]         num,
    input  logic [47:0]         den,
    output psvos_pkg::div_res_t res
);

    logic        active_reg;
    logic        done_reg;
    logic [4:0]  step_reg;
    logic [47:0] rem_reg;
    logic [31:0] q_reg;
    logic [47:0] den_reg;
    logic        ovf_reg;
    logic [48:0] trial;
    logic        fits;

    // One quotient bit per cycle
    assign trial = {rem_reg, q_reg[31]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                step_reg   <= '0;
            end
            else if (active_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {16'd0, num[63:32]};
            q_reg   <= num[31:0];
            den_reg <= den;
            ovf_reg <= ({16'd0, num[63:32]} >= den);
        end
        else if (active_reg)
        begin
            rem_reg <= fits ? 48'(trial - {1'b0, den_reg}) : trial[47:0];
            q_reg   <= {q_reg[30:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = q_reg;

`ifndef SYNTHESIS
    // A new division only starts once the last one is over
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !active_reg)
        else $error("divider restarted while busy");
`endif

endmodule

// ===== design/psvos_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psvos_back
// Execution side: statistics table, update sequencer sharing one divider
// for VWAP and basis-point change, and the result register.
// ----------------------------------------------------------------------------
module psvos_back #(
    parameter int SYMBOLS = psvos_pkg::SYMBOLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  psvos_pkg::item_t    q_item,
    output logic                q_pop,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [7:0]          symbol_echo,
    output logic [31:0]         last_px,
    output logic [31:0]         open_price,
    output logic [31:0]         high_price,
    output logic [31:0]         low_price,
    output logic [47:0]         volume_total,
    output logic [31:0]         tick_total,
    output logic [31:0]         vwap,
    output logic signed [32:0]  px_change,
    output logic signed [31:0]  change_bp
);

    localparam int SYM_W = $clog2(SYMBOLS);

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_LOAD    = 9'b000000100,
        S_UPD     = 9'b000001000,
        S_VW      = 9'b000010000,
        S_VW_WAIT = 9'b000100000,
        S_BP      = 9'b001000000,
        S_BP_WAIT = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [SYM_W-1:0]    clr_idx_reg;
    logic                clr_item_reg;
    logic                out_valid_reg;

    psvos_pkg::stats_t   mem [SYMBOLS];
    psvos_pkg::stats_t   rd_data_reg;
    psvos_pkg::stats_t   wr_data;
    logic [SYM_W-1:0]    wr_addr;
    logic                wr_en;
    logic                rd_en;

    psvos_pkg::item_t    item_reg;
    psvos_pkg::stats_t   cur_reg;
    psvos_pkg::status_t  status_reg;
    logic [55:0]         pv_reg;
    logic [45:0]         bp_num_reg;
    logic                neg_reg;
    logic [31:0]         vwap_reg;
    logic [31:0]         bp_reg;

    psvos_pkg::stats_t   base;
    psvos_pkg::stats_t   upd;
    logic [48:0]         vsum;
    logic [64:0]         pvsum;
    logic [31:0]         diffmag;

    logic                div_start;
    logic [63:0]         div_num;
    logic [47:0]         div_den;
    psvos_pkg::div_res_t div_res;

    logic                out_load;
    logic                stats_on;

    logic [2:0]          out_status_reg;
    logic [7:0]          out_symbol_reg;
    logic [31:0]         out_last_reg;
    logic [31:0]         out_open_reg;
    logic [31:0]         out_high_reg;
    logic [31:0]         out_low_reg;
    logic [47:0]         out_vol_reg;
    logic [31:0]         out_cnt_reg;
    logic [31:0]         out_vwap_reg;
    logic [32:0]         out_chg_reg;
    logic [31:0]         out_bp_reg;

    psvos_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .res   (div_res)
    );

    // Tick update of one slot
    always_comb
    begin
        base = cur_reg;
        if (!cur_reg.valid)
        begin
            base.valid = 1'b1;
            base.sat   = 1'b0;
            base.open  = item_reg.price;
            base.high  = item_reg.price;
            base.low   = item_reg.price;
            base.vol   = '0;
            base.cnt   = '0;
            base.pv    = '0;
        end
        upd      = base;
        upd.last = item_reg.price;
        if (item_reg.price > base.high)
        begin
            upd.high = item_reg.price;
        end
        if (item_reg.price < base.low)
        begin
            upd.low = item_reg.price;
        end
        vsum = {1'b0, base.vol} + 49'(item_reg.volume);
        if (vsum[48])
        begin
            upd.vol = '1;
            upd.sat = 1'b1;
        end
        else
        begin
            upd.vol = vsum[47:0];
        end
        if (&base.cnt)
        begin
            upd.sat = 1'b1;
        end
        else
        begin
            upd.cnt = base.cnt + 32'd1;
        end
        pvsum = {1'b0, base.pv} + 65'(pv_reg);
        if (pvsum[64])
        begin
            upd.pv  = '1;
            upd.sat = 1'b1;
        end
        else
        begin
            upd.pv = pvsum[63:0];
        end
    end

    // Magnitude of the change from the open
    assign diffmag = (cur_reg.last >= cur_reg.open) ? (cur_reg.last - cur_reg.open)
                                                    : (cur_reg.open - cur_reg.last);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign clearing = (state_reg == S_CLEAR);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = q_item.slot[SYM_W-1:0];
        wr_data    = '0;
        div_start  = 1'b0;
        div_num    = cur_reg.pv;
        div_den    = cur_reg.vol;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                if (clr_idx_reg == SYM_W'(SYMBOLS - 1))
                begin
                    state_next = clr_item_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_item.func)
                        psvos_pkg::FN_TICK:
                        begin
                            if (q_item.price == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_LOAD;
                            end
                        end
                        psvos_pkg::FN_QUERY:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_LOAD;
                        end
                        psvos_pkg::FN_RST_ONE:
                        begin
                            wr_en      = 1'b1;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_CLEAR;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                if (item_reg.func == psvos_pkg::FN_TICK)
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    state_next = rd_data_reg.valid ? S_VW : S_DONE;
                end
            end
            S_UPD:
            begin
                wr_en      = 1'b1;
                wr_addr    = item_reg.slot[SYM_W-1:0];
                wr_data    = upd;
                state_next = S_VW;
            end
            S_VW:
            begin
                div_start  = 1'b1;
                state_next = S_VW_WAIT;
            end
            S_VW_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = S_BP;
                end
            end
            S_BP:
            begin
                div_start  = 1'b1;
                div_num    = {18'd0, bp_num_reg};
                div_den    = {16'd0, cur_reg.open};
                state_next = S_BP_WAIT;
            end
            S_BP_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            clr_item_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + SYM_W'(1);
            end
            else
            begin
                clr_idx_reg <= '0;
            end
            if (state_reg == S_IDLE)
            begin
                clr_item_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Statistics table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[q_item.slot[SYM_W-1:0]];
        end
    end

    // Work registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
            unique case (q_item.func)
                psvos_pkg::FN_TICK:
                begin
                    status_reg <= psvos_pkg::ST_BAD;
                end
                psvos_pkg::FN_QUERY:
                begin
                    status_reg <= psvos_pkg::ST_NOTFOUND;
                end
                default:
                begin
                    status_reg <= psvos_pkg::ST_RESET;
                end
            endcase
        end
        if (state_reg == S_LOAD)
        begin
            cur_reg <= rd_data_reg;
            pv_reg  <= 56'(item_reg.price) * 56'(item_reg.volume);
            if (item_reg.func == psvos_pkg::FN_QUERY && rd_data_reg.valid)
            begin
                status_reg <= psvos_pkg::ST_FOUND;
            end
        end
        if (state_reg == S_UPD)
        begin
            cur_reg    <= upd;
            status_reg <= upd.sat ? psvos_pkg::ST_SAT : psvos_pkg::ST_APPLIED;
        end
        if (state_reg == S_VW)
        begin
            bp_num_reg <= 46'(diffmag) * 46'(psvos_pkg::BP_SCALE);
            neg_reg    <= (cur_reg.last < cur_reg.open);
        end
        if (state_reg == S_VW_WAIT && div_res.done)
        begin
            if (cur_reg.vol == '0)
            begin
                vwap_reg <= cur_reg.last;
            end
            else
            begin
                vwap_reg <= div_res.ovf ? psvos_pkg::VWAP_MAX : div_res.quot;
            end
        end
        if (state_reg == S_BP_WAIT && div_res.done)
        begin
            if (cur_reg.open == '0)
            begin
                bp_reg <= '0;
            end
            else if (!neg_reg)
            begin
                bp_reg <= (div_res.ovf || div_res.quot[31]) ? psvos_pkg::BP_MAX
                                                            : div_res.quot;
            end
            else
            begin
                bp_reg <= 32'd0 - div_res.quot;
            end
        end
    end

    // Result register
    assign stats_on = (status_reg == psvos_pkg::ST_APPLIED) ||
                      (status_reg == psvos_pkg::ST_SAT) ||
                      (status_reg == psvos_pkg::ST_FOUND);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_symbol_reg <= item_reg.symbol;
            out_last_reg   <= stats_on ? cur_reg.last : '0;
            out_open_reg   <= stats_on ? cur_reg.open : '0;
            out_high_reg   <= stats_on ? cur_reg.high : '0;
            out_low_reg    <= stats_on ? cur_reg.low : '0;
            out_vol_reg    <= stats_on ? cur_reg.vol : '0;
            out_cnt_reg    <= stats_on ? cur_reg.cnt : '0;
            out_vwap_reg   <= stats_on ? vwap_reg : '0;
            out_chg_reg    <= stats_on ? ({1'b0, cur_reg.last} - {1'b0, cur_reg.open}) : '0;
            out_bp_reg     <= stats_on ? bp_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign symbol_echo  = out_symbol_reg;
    assign last_px      = out_last_reg;
    assign open_price   = out_open_reg;
    assign high_price   = out_high_reg;
    assign low_price    = out_low_reg;
    assign volume_total = out_vol_reg;
    assign tick_total   = out_cnt_reg;
    assign vwap         = out_vwap_reg;
    assign px_change    = out_chg_reg;
    assign change_bp    = out_bp_reg;

`ifndef SYNTHESIS
    // No item is taken from the queue during a table sweep
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("queue popped during table clear");

    // An applied or saturating tick keeps last inside the session range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == psvos_pkg::ST_APPLIED ||
                           out_status_reg == psvos_pkg::ST_SAT))
        |-> (out_low_reg <= out_last_reg) && (out_last_reg <= out_high_reg))
        else $error("last price outside low/high");

    // A miss reports empty statistics
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == psvos_pkg::ST_NOTFOUND)
        |-> (out_cnt_reg == '0) && (out_vol_reg == '0))
        else $error("miss carries statistics");
`endif

endmodule

// ===== dv/per_symbol_vwap_ohlc_stats_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_symbol_vwap_ohlc_stats_tb
// Self-checking bench for the per-symbol tick statistics block. A behavioral
// slot table predicts each result when the item is accepted. A monitor
// compares every result field against the oldest prediction. Directed items
// cover the edge cases, then pv saturation runs on one symbol. Random traffic
// over a few symbols follows, with random gaps on both channels. A closing
// stretch runs with no idling at all.
// ----------------------------------------------------------------------------
module per_symbol_vwap_ohlc_stats_tb;

    typedef struct {
        psvos_pkg::status_t status;
        logic [7:0]  symbol;
        logic [31:0] last_px;
        logic [31:0] open_px;
        logic [31:0] high_px;
        logic [31:0] low_px;
        logic [47:0] tot_vol;
        logic [31:0] ticks;
        logic [31:0] vwap_px;
        logic [32:0] change;
        logic [31:0] bp;
    } stats_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = psvos_pkg::FN_QUERY;
    logic [7:0]         symbol_id = '0;
    logic [31:0]        price = '0;
    logic [23:0]        volume = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic [7:0]         symbol_echo;
    logic [31:0]        last_px;
    logic [31:0]        open_price;
    logic [31:0]        high_price;
    logic [31:0]        low_price;
    logic [47:0]        volume_total;
    logic [31:0]        tick_total;
    logic [31:0]        vwap;
    logic signed [32:0] px_change;
    logic signed [31:0] change_bp;

    // Shadow slot table
    logic        sess_live [256];
    logic        sess_sat  [256];
    logic [31:0] sess_open [256];
    logic [31:0] sess_high [256];
    logic [31:0] sess_low  [256];
    logic [31:0] sess_last [256];
    logic [47:0] sess_vol  [256];
    logic [31:0] sess_cnt  [256];
    logic [63:0] sess_pv   [256];

    stats_result_t pending_stats[$];
    int            fail_count = 0;
    bit            gaps_on = 1'b1;
    int            stall_left = 0;

    per_symbol_vwap_ohlc_stats dut (.*);

    always #10 clk = ~clk;

    // Stats fields of a live slot
    function automatic void slot_stats(input int s, inout stats_result_t r);
        logic [63:0] lst;
        logic [63:0] opn;
        logic [63:0] q;
        logic [63:0] mag;
        lst = sess_last[s];
        opn = sess_open[s];
        if (sess_vol[s] == 0)
            q = lst;
        else
        begin
            q = sess_pv[s] / sess_vol[s];
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        end
        if (lst >= opn)
        begin
            mag = ((lst - opn) * 64'd10000) / opn;
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            r.bp = mag[31:0];
        end
        else
        begin
            mag = ((opn - lst) * 64'd10000) / opn;
            r.bp = 32'd0 - mag[31:0];
        end
        r.last_px = sess_last[s];
        r.open_px = sess_open[s];
        r.high_px = sess_high[s];
        r.low_px  = sess_low[s];
        r.tot_vol = sess_vol[s];
        r.ticks   = sess_cnt[s];
        r.vwap_px = q[31:0];
        r.change  = {1'b0, sess_last[s]} - {1'b0, sess_open[s]};
    endfunction

    // Apply one item to the shadow table and return its result
    function automatic stats_result_t apply_item(input psvos_pkg::func_t f,
                                                 input logic [7:0] sym,
                                                 input logic [31:0] px,
                                                 input logic [23:0] vol);
        stats_result_t r;
        int s;
        logic [48:0] vsum;
        logic [64:0] pvsum;
        r = '{status: psvos_pkg::ST_APPLIED, symbol: sym, default: '0};
        s = sym;
        case (f)
            psvos_pkg::FN_TICK:
            begin
                if (px == 0)
                    r.status = psvos_pkg::ST_BAD;
                else
                begin
                    if (!sess_live[s])
                    begin
                        sess_live[s] = 1'b1;
                        sess_open[s] = px;
                        sess_high[s] = px;
                        sess_low[s]  = px;
                        sess_vol[s]  = '0;
                        sess_cnt[s]  = '0;
                        sess_pv[s]   = '0;
                        sess_sat[s]  = 1'b0;
                    end
                    sess_last[s] = px;
                    if (px > sess_high[s]) sess_high[s] = px;
                    if (px < sess_low[s]) sess_low[s] = px;
                    vsum = {1'b0, sess_vol[s]} + vol;
                    if (vsum[48])
                    begin
                        sess_vol[s] = '1;
                        sess_sat[s] = 1'b1;
                    end
                    else
                        sess_vol[s] = vsum[47:0];
                    if (sess_cnt[s] == 32'hFFFF_FFFF)
                        sess_sat[s] = 1'b1;
                    else
                        sess_cnt[s] = sess_cnt[s] + 32'd1;
                    pvsum = {1'b0, sess_pv[s]} + 65'(64'(px) * 64'(vol));
                    if (pvsum[64])
                    begin
                        sess_pv[s]  = '1;
                        sess_sat[s] = 1'b1;
                    end
                    else
                        sess_pv[s] = pvsum[63:0];
                    r.status = sess_sat[s] ? psvos_pkg::ST_SAT : psvos_pkg::ST_APPLIED;
                    slot_stats(s, r);
                end
            end
            psvos_pkg::FN_QUERY:
            begin
                if (sess_live[s])
                begin
                    r.status = psvos_pkg::ST_FOUND;
                    slot_stats(s, r);
                end
                else
                    r.status = psvos_pkg::ST_NOTFOUND;
            end
            psvos_pkg::FN_RST_ONE:
            begin
                sess_live[s] = 1'b0;
                r.status = psvos_pkg::ST_RESET;
            end
            default:
            begin
                foreach (sess_live[i]) sess_live[i] = 1'b0;
                r.status = psvos_pkg::ST_RESET;
            end
        endcase
        return r;
    endfunction

    // Drive one item, wait for acceptance, record its prediction
    task automatic send_item(input psvos_pkg::func_t f, input logic [7:0] sym,
                             input logic [31:0] px, input logic [23:0] vol);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        symbol_id <= sym;
        price     <= px;
        volume    <= vol;
        do @(posedge clk); while (in_stall);
        pending_stats = {pending_stats, apply_item(f, sym, px, vol)};
    endtask

    task automatic test_directed();
        send_item(psvos_pkg::FN_QUERY, 8'd7, 32'd0, 24'd0);              // unknown symbol
        send_item(psvos_pkg::FN_TICK, 8'd7, 32'd0, 24'hFFFFFF);           // bad price
        send_item(psvos_pkg::FN_TICK, 8'd7, 32'd1000000, 24'd0);          // zero volume
        send_item(psvos_pkg::FN_TICK, 8'd7, 32'd1200000, 24'd500);        // new high
        send_item(psvos_pkg::FN_TICK, 8'd7, 32'd900000, 24'd300);         // new low
        send_item(psvos_pkg::FN_QUERY, 8'd7, 32'hFFFF_FFFF, 24'hFFFFFF);
        send_item(psvos_pkg::FN_TICK, 8'd0, 32'd1, 24'd1);                // tiny open
        send_item(psvos_pkg::FN_TICK, 8'd0, 32'hFFFF_FFFF, 24'hFFFFFF);   // positive bp clamp
        send_item(psvos_pkg::FN_TICK, 8'd255, 32'hFFFF_FFFF, 24'd1);
        send_item(psvos_pkg::FN_TICK, 8'd255, 32'd1, 24'hFFFFFF);         // deep negative bp
        send_item(psvos_pkg::FN_QUERY, 8'd255, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_RST_ONE, 8'd7, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_QUERY, 8'd7, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_QUERY, 8'd0, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_TICK, 8'd7, 32'd5, 24'd2);                // reopened session
        send_item(psvos_pkg::FN_RST_ALL, 8'd200, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_QUERY, 8'd0, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_QUERY, 8'd255, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_TICK, 8'd0, 32'd77, 24'd0);
    endtask

    // Max price times max volume overflows the pv sum after about 256 ticks
    task automatic test_saturation();
        repeat (262) send_item(psvos_pkg::FN_TICK, 8'd42, 32'hFFFF_FFFF, 24'hFFFFFF);
        send_item(psvos_pkg::FN_TICK, 8'd42, 32'd3, 24'd1);
        send_item(psvos_pkg::FN_QUERY, 8'd42, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_RST_ONE, 8'd42, 32'd0, 24'd0);
        send_item(psvos_pkg::FN_TICK, 8'd42, 32'd10, 24'd10);             // flag cleared
    endtask

    task automatic test_random(input int count);
        int     k;
        int     sel;
        psvos_pkg::func_t f;
        logic [31:0] px;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70) f = psvos_pkg::FN_TICK;
            else if (sel < 92) f = psvos_pkg::FN_QUERY;
            else if (sel < 99) f = psvos_pkg::FN_RST_ONE;
            else f = psvos_pkg::FN_RST_ALL;
            case ($urandom_range(0, 3))
                0: px = $urandom;
                1: px = $urandom_range(0, 20);
                default: px = 32'd1000000 + $urandom_range(0, 200000) - 32'd100000;
            endcase
            if (f == psvos_pkg::FN_TICK && px == 0 && $urandom_range(0, 3) != 0) px = 32'd1;
            send_item(f, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                      px, ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 999)));
        end
    endtask

    // Output stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        stats_result_t e;
        if (out_valid && !out_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                $error("result with no pending item, symbol_echo %0d", symbol_echo);
                fail_count++;
            end
            else
            begin
                e = pending_stats[0];
                pending_stats.delete(0);
                check_field("status", e.status, status);
                check_field("symbol_echo", e.symbol, symbol_echo);
                check_field("last_px", e.last_px, last_px);
                check_field("open_price", e.open_px, open_price);
                check_field("high_price", e.high_px, high_price);
                check_field("low_price", e.low_px, low_price);
                check_field("volume_total", e.tot_vol, volume_total);
                check_field("tick_total", e.ticks, tick_total);
                check_field("vwap", e.vwap_px, vwap);
                check_field("px_change", e.change, $unsigned(px_change));
                check_field("change_bp", e.bp, $unsigned(change_bp));
            end
        end
    end

    initial
    begin
        foreach (sess_live[i]) sess_live[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_saturation();
        test_random(1000);
        gaps_on = 1'b0;
        test_random(200);
        in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending_stats.size() == 0)
            $display("per_symbol_vwap_ohlc_stats_tb OK");
        else
            $display("per_symbol_vwap_ohlc_stats_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40ms;
        $display("per_symbol_vwap_ohlc_stats_tb NOT OK");
        $finish;
    end

endmodule

// ===== per_symbol_vwap_ohlc_stats.f =====
design/psvos_pkg.sv
design/psvos_front.sv
design/psvos_div.sv
design/psvos_back.sv
design/per_symbol_vwap_ohlc_stats.sv
dv/per_symbol_vwap_ohlc_stats_tb.sv
